@@ hw/rtl/ftint_pkg.sv @@
// Shared types, constants and widths of the flow trajectory integrator.
`default_nettype none
package ftint_pkg;

    localparam int MAX_WINDOW       = 64;
    localparam int WIN_AW           = $clog2(MAX_WINDOW);
    localparam int WIN_FILL_W       = $clog2(MAX_WINDOW + 1);
    localparam int MAX_FRAME_PIXELS = 2097152;
    localparam int CNT_W            = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int TRACK_WIDTH      = 800;
    localparam int TRACK_HEIGHT     = 600;

    localparam int SUM_W      = 38;
    localparam int WSUM_W     = 31;
    localparam int POS_W      = 26;
    localparam int MUL_W      = 31;
    localparam int DIV_NUM_W  = 61;
    localparam int DIV_DEN_W  = 32;
    localparam int SQ_IN_W    = 32;
    localparam int SQ_ROOT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W   = SQ_ROOT_W + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [POS_W-1:0] POS_X_RESET = POS_W'((TRACK_WIDTH << 16) / 2);
    localparam logic [POS_W-1:0] POS_Y_RESET = POS_W'((TRACK_HEIGHT << 16) / 2);
    localparam logic [POS_W-1:0] POS_X_MAX   = POS_W'((TRACK_WIDTH - 1) << 16);
    localparam logic [POS_W-1:0] POS_Y_MAX   = POS_W'((TRACK_HEIGHT - 1) << 16);

    localparam logic [14:0] CLIP_RESET = 15'd2560;
    localparam logic [15:0] THR_RESET  = 16'd655;
    localparam logic [6:0]  WLEN_RESET = 7'd5;
    localparam logic [15:0] GAIN_RESET = 16'd6400;

    localparam logic [1:0] CFG_CLIP = 2'd0;
    localparam logic [1:0] CFG_THR  = 2'd1;
    localparam logic [1:0] CFG_WLEN = 2'd2;
    localparam logic [1:0] CFG_GAIN = 2'd3;

    typedef struct packed {
        logic [14:0] clip;
        logic [15:0] thr;
        logic [6:0]  wlen;
        logic [15:0] gain;
    } cfg_t;

    typedef struct packed {
        logic               frame_end;
        logic signed [15:0] flow_dy;
        logic signed [15:0] flow_dx;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic                 done;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_REM_W-1:0]  rem;
    } sqrt_rsp_t;

    typedef struct packed {
        logic [21:0]        unclipped_count;
        logic [15:0]        peak_magnitude;
        logic [23:0]        mag_mean;
        logic [15:0]        track_y;
        logic [15:0]        track_x;
        logic signed [23:0] smooth_dy;
        logic signed [23:0] smooth_dx;
        logic signed [23:0] clipped_mean_dy;
        logic signed [23:0] clipped_mean_dx;
        logic signed [23:0] mean_dy;
        logic signed [23:0] mean_dx;
    } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ftint_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ftint_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ftint_pkg::div_req_t req,
    output ftint_pkg::div_rsp_t      rsp
);
    localparam int NW = ftint_pkg::DIV_NUM_W;
    localparam int DW = ftint_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                // The dividend shifts out at the top while quotient bits enter below.
                if (!diff[DW+1]) begin
                    rem_reg <= diff[DW-1:0];
                    num_reg <= {num_reg[NW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[DW-1:0];
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                end
                cnt_reg  <= cnt_reg + CW'(1);
                done_reg <= (cnt_reg == CW'(NW - 1));
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
endmodule
`default_nettype wire

@@ hw/rtl/ftint_sqrt.sv @@
// Digit-by-digit integer square root with remainder, two input bits per cycle.
`default_nettype none
module ftint_sqrt (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ftint_pkg::sqrt_req_t req,
    output ftint_pkg::sqrt_rsp_t      rsp
);
    localparam int IW = ftint_pkg::SQ_IN_W;
    localparam int RW = ftint_pkg::SQ_ROOT_W;
    localparam int MW = ftint_pkg::SQ_REM_W;
    localparam int CW = $clog2(RW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] val_reg;
    logic [RW-1:0] root_reg;
    logic [MW-1:0] rem_reg;
    logic [MW+1:0] rem_sh;
    logic [MW+1:0] trial;

    assign rem_sh = {rem_reg, val_reg[IW-1:IW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
                val_reg  <= req.value;
                root_reg <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                val_reg <= {val_reg[IW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= MW'(rem_sh - trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg  <= MW'(rem_sh);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                cnt_reg  <= cnt_reg + CW'(1);
                done_reg <= (cnt_reg == CW'(RW - 1));
                if (cnt_reg == CW'(RW - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

@@ hw/rtl/ftint_front.sv @@
// Input side: accepts flow vectors and queues them for the back end.
`default_nettype none
module ftint_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,
    input  wire logic              s_tlast,
    output logic                   q_valid,
    output ftint_pkg::item_t       q_item,
    input  wire logic              q_pop
);
    localparam int AW    = ftint_pkg::FIFO_AW;
    localparam int DEPTH = ftint_pkg::FIFO_DEPTH;

    ftint_pkg::item_t   fifo_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               push;
    logic               pop;

    assign s_tready = (count_reg != (AW+1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{frame_end: s_tlast,
                                      flow_dy: s_tdata[31:16],
                                      flow_dx: s_tdata[15:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ftint_back.sv @@
// Back end: per-pixel accumulation, frame statistics, window average and position.
`default_nettype none
module ftint_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ftint_pkg::cfg_t  cfg,
    input  wire logic             q_valid,
    input  wire ftint_pkg::item_t q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ftint_pkg::result_t    m_result
);
    localparam int SW  = ftint_pkg::SUM_W;
    localparam int WSW = ftint_pkg::WSUM_W;
    localparam int PW  = ftint_pkg::POS_W;
    localparam int MW  = ftint_pkg::MUL_W;
    localparam int NW  = ftint_pkg::DIV_NUM_W;
    localparam int DW  = ftint_pkg::DIV_DEN_W;
    localparam int CW  = ftint_pkg::CNT_W;
    localparam int AW  = ftint_pkg::WIN_AW;
    localparam int FW  = ftint_pkg::WIN_FILL_W;

    localparam logic [2:0] SEL_MX  = 3'd0;
    localparam logic [2:0] SEL_MY  = 3'd1;
    localparam logic [2:0] SEL_CX  = 3'd2;
    localparam logic [2:0] SEL_CY  = 3'd3;
    localparam logic [2:0] SEL_MAG = 3'd4;
    localparam logic [2:0] SEL_AX  = 3'd5;
    localparam logic [2:0] SEL_AY  = 3'd6;

    typedef enum logic [4:0] {
        ST_FETCH, ST_SQX, ST_SQY, ST_CLIPSQ, ST_LEN, ST_LEN_WAIT,
        ST_CP_MUL1, ST_CP_MUL2, ST_CP_DIV, ST_CP_DIV_WAIT, ST_CP_SQRT_WAIT,
        ST_END, ST_DIV, ST_DIV_WAIT, ST_W_CHK, ST_W_SUB, ST_W_PUSH,
        ST_T_SQX, ST_T_SQY, ST_T_THR, ST_T_CMP, ST_P_X, ST_P_XA, ST_P_YA, ST_OUT
    } state_t;

    state_t                 state_reg;
    ftint_pkg::item_t       item_reg;
    logic [31:0]            s_reg;
    logic [29:0]            clipsq_reg;
    logic                   comp_sel_reg;
    logic signed [SW-1:0]   raw_x_reg, raw_y_reg, clip_x_reg, clip_y_reg;
    logic [SW-1:0]          mag_sum_reg;
    logic [15:0]            peak_reg;
    logic [CW-1:0]          pix_cnt_reg;
    logic [CW-1:0]          kept_reg;
    logic [2:0]             sel_reg;
    logic signed [23:0]     mdx_reg, mdy_reg, cdx_reg, cdy_reg, ax_reg, ay_reg;
    logic [23:0]            mmag_reg;
    logic [FW-1:0]          fill_reg;
    logic [AW-1:0]          head_reg;
    logic signed [WSW-1:0]  wsum_x_reg, wsum_y_reg;
    logic [47:0]            t_reg;
    logic [PW-1:0]          pos_x_reg, pos_y_reg;
    logic [2*MW-1:0]        mul_p_reg;
    logic [47:0]            win_mem [ftint_pkg::MAX_WINDOW];
    logic [47:0]            rd_data_reg;
    logic                   out_valid_reg;
    ftint_pkg::result_t     out_reg;

    logic [MW-1:0]          mul_a, mul_b;
    logic [15:0]            adx, ady;
    logic [23:0]            aax, aay;
    logic [16:0]            len;
    logic [FW-1:0]          lim;
    logic [AW-1:0]          rd_addr;
    logic                   div_neg;
    logic [23:0]            div_q24;
    logic signed [23:0]     div_res;
    ftint_pkg::div_req_t    div_req;
    ftint_pkg::div_rsp_t    div_rsp;
    ftint_pkg::sqrt_req_t   sq_req;
    ftint_pkg::sqrt_rsp_t   sq_rsp;

    function automatic logic [SW-1:0] abs_sum(input logic signed [SW-1:0] v);
        return v[SW-1] ? SW'(-v) : SW'(v);
    endfunction

    function automatic logic [WSW-1:0] abs_wsum(input logic signed [WSW-1:0] v);
        return v[WSW-1] ? WSW'(-v) : WSW'(v);
    endfunction

    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        return v[23] ? 24'(-v) : 24'(v);
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    // Moves a position by a signed step and clamps it to [0, hi].
    function automatic logic [PW-1:0] move_pos(input logic [PW-1:0] pos, input logic neg,
                                               input logic [33:0] mag, input logic [PW-1:0] hi);
        logic signed [36:0] step;
        logic signed [36:0] sum;
        step = $signed({3'b000, mag});
        sum  = $signed(37'(pos)) + (neg ? -step : step);
        if (sum < 0) begin
            return '0;
        end else if (sum > $signed(37'(hi))) begin
            return hi;
        end else begin
            return sum[PW-1:0];
        end
    endfunction

    ftint_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));
    ftint_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .req(sq_req), .rsp(sq_rsp));

    assign adx     = abs16(item_reg.flow_dx);
    assign ady     = abs16(item_reg.flow_dy);
    assign aax     = abs24(ax_reg);
    assign aay     = abs24(ay_reg);
    assign len     = 17'(sq_rsp.root) + ((sq_rsp.rem > ftint_pkg::SQ_REM_W'(sq_rsp.root))
                                         ? 17'd1 : 17'd0);
    assign rd_addr = head_reg - fill_reg[AW-1:0];
    assign q_pop   = (state_reg == ST_FETCH) && q_valid;

    always_comb begin
        if (cfg.wlen == '0) begin
            lim = FW'(1);
        end else if (FW'(cfg.wlen) > FW'(ftint_pkg::MAX_WINDOW)) begin
            lim = FW'(ftint_pkg::MAX_WINDOW);
        end else begin
            lim = FW'(cfg.wlen);
        end
    end

    // Shared multiplier operands; the product is registered every cycle.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQX:     begin mul_a = MW'(adx);  mul_b = MW'(adx);  end
            ST_SQY:     begin mul_a = MW'(ady);  mul_b = MW'(ady);  end
            ST_CLIPSQ:  begin mul_a = MW'(cfg.clip); mul_b = MW'(cfg.clip); end
            ST_CP_MUL1: begin
                mul_a = MW'(comp_sel_reg ? ady : adx);
                mul_b = MW'(cfg.clip);
            end
            ST_CP_MUL2: begin mul_a = mul_p_reg[MW-1:0]; mul_b = mul_p_reg[MW-1:0]; end
            ST_T_SQX:   begin mul_a = MW'(aax); mul_b = MW'(aax); end
            ST_T_SQY:   begin mul_a = MW'(aay); mul_b = MW'(aay); end
            ST_T_THR:   begin mul_a = MW'(cfg.thr); mul_b = MW'(cfg.thr); end
            ST_P_X:     begin mul_a = MW'(aax); mul_b = MW'(cfg.gain); end
            ST_P_XA:    begin mul_a = MW'(aay); mul_b = MW'(cfg.gain); end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
    end

    always_comb begin
        div_req.start = (state_reg == ST_CP_DIV) || (state_reg == ST_DIV);
        div_req.num   = mul_p_reg[NW-1:0];
        div_req.den   = s_reg;
        div_neg       = 1'b0;
        if (state_reg != ST_CP_DIV) begin
            div_req.den = DW'(pix_cnt_reg);
            unique case (sel_reg)
                SEL_MX:  begin div_req.num = NW'({abs_sum(raw_x_reg), 8'd0});
                               div_neg = raw_x_reg[SW-1]; end
                SEL_MY:  begin div_req.num = NW'({abs_sum(raw_y_reg), 8'd0});
                               div_neg = raw_y_reg[SW-1]; end
                SEL_CX:  begin div_req.num = NW'({abs_sum(clip_x_reg), 8'd0});
                               div_neg = clip_x_reg[SW-1]; end
                SEL_CY:  begin div_req.num = NW'({abs_sum(clip_y_reg), 8'd0});
                               div_neg = clip_y_reg[SW-1]; end
                SEL_MAG: div_req.num = NW'({mag_sum_reg, 8'd0});
                SEL_AX:  begin div_req.num = NW'(abs_wsum(wsum_x_reg));
                               div_req.den = DW'(fill_reg); div_neg = wsum_x_reg[WSW-1]; end
                SEL_AY:  begin div_req.num = NW'(abs_wsum(wsum_y_reg));
                               div_req.den = DW'(fill_reg); div_neg = wsum_y_reg[WSW-1]; end
                default: div_req.num = '0;
            endcase
        end
    end

    assign div_q24 = div_rsp.quo[23:0];
    assign div_res = div_neg ? $signed(24'(-div_q24)) : $signed(div_q24);

    always_comb begin
        sq_req.start = (state_reg == ST_LEN) ||
                       ((state_reg == ST_CP_DIV_WAIT) && div_rsp.done);
        sq_req.value = (state_reg == ST_LEN) ? s_reg : div_rsp.quo[31:0];
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_W_PUSH) begin
            win_mem[head_reg] <= {cdy_reg, cdx_reg};
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FETCH;
            comp_sel_reg  <= 1'b0;
            sel_reg       <= SEL_MX;
            raw_x_reg     <= '0;
            raw_y_reg     <= '0;
            clip_x_reg    <= '0;
            clip_y_reg    <= '0;
            mag_sum_reg   <= '0;
            peak_reg      <= '0;
            pix_cnt_reg   <= '0;
            kept_reg      <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            wsum_x_reg    <= '0;
            wsum_y_reg    <= '0;
            pos_x_reg     <= ftint_pkg::POS_X_RESET;
            pos_y_reg     <= ftint_pkg::POS_Y_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            // In ST_OUT the output register is handled by the state itself.
            if (m_ready && state_reg != ST_OUT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_FETCH: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        // Pixels past the frame limit add nothing.
                        state_reg <= (pix_cnt_reg < CW'(ftint_pkg::MAX_FRAME_PIXELS))
                                     ? ST_SQX : ST_END;
                    end
                end
                ST_SQX: state_reg <= ST_SQY;
                ST_SQY: begin
                    s_reg     <= mul_p_reg[31:0];
                    state_reg <= ST_CLIPSQ;
                end
                ST_CLIPSQ: begin
                    s_reg     <= s_reg + mul_p_reg[31:0];
                    state_reg <= ST_LEN;
                end
                ST_LEN: begin
                    clipsq_reg <= mul_p_reg[29:0];
                    state_reg  <= ST_LEN_WAIT;
                end
                ST_LEN_WAIT: begin
                    if (sq_rsp.done) begin
                        raw_x_reg   <= raw_x_reg + SW'(item_reg.flow_dx);
                        raw_y_reg   <= raw_y_reg + SW'(item_reg.flow_dy);
                        mag_sum_reg <= mag_sum_reg + SW'(len);
                        if (len[15:0] > peak_reg) peak_reg <= len[15:0];
                        pix_cnt_reg <= pix_cnt_reg + CW'(1);
                        if (s_reg > 32'(clipsq_reg)) begin
                            comp_sel_reg <= 1'b0;
                            state_reg    <= ST_CP_MUL1;
                        end else begin
                            clip_x_reg <= clip_x_reg + SW'(item_reg.flow_dx);
                            clip_y_reg <= clip_y_reg + SW'(item_reg.flow_dy);
                            kept_reg   <= kept_reg + CW'(1);
                            state_reg  <= ST_END;
                        end
                    end
                end
                ST_CP_MUL1: state_reg <= ST_CP_MUL2;
                ST_CP_MUL2: state_reg <= ST_CP_DIV;
                ST_CP_DIV:  state_reg <= ST_CP_DIV_WAIT;
                ST_CP_DIV_WAIT: begin
                    if (div_rsp.done) state_reg <= ST_CP_SQRT_WAIT;
                end
                ST_CP_SQRT_WAIT: begin
                    if (sq_rsp.done) begin
                        if (!comp_sel_reg) begin
                            clip_x_reg   <= item_reg.flow_dx[15] ? clip_x_reg - SW'(sq_rsp.root)
                                                                 : clip_x_reg + SW'(sq_rsp.root);
                            comp_sel_reg <= 1'b1;
                            state_reg    <= ST_CP_MUL1;
                        end else begin
                            clip_y_reg <= item_reg.flow_dy[15] ? clip_y_reg - SW'(sq_rsp.root)
                                                               : clip_y_reg + SW'(sq_rsp.root);
                            state_reg  <= ST_END;
                        end
                    end
                end
                ST_END: begin
                    sel_reg   <= SEL_MX;
                    state_reg <= item_reg.frame_end ? ST_DIV : ST_FETCH;
                end
                ST_DIV: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        unique case (sel_reg)
                            SEL_MX:  mdx_reg  <= div_res;
                            SEL_MY:  mdy_reg  <= div_res;
                            SEL_CX:  cdx_reg  <= div_res;
                            SEL_CY:  cdy_reg  <= div_res;
                            SEL_MAG: mmag_reg <= div_q24;
                            SEL_AX:  ax_reg   <= div_res;
                            SEL_AY:  ay_reg   <= div_res;
                            default: mmag_reg <= mmag_reg;
                        endcase
                        if (sel_reg == SEL_MAG) begin
                            state_reg <= ST_W_CHK;
                        end else if (sel_reg == SEL_AY) begin
                            state_reg <= ST_T_SQX;
                        end else begin
                            sel_reg   <= sel_reg + 3'd1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_W_CHK: state_reg <= (fill_reg >= lim) ? ST_W_SUB : ST_W_PUSH;
                ST_W_SUB: begin
                    // Drops the oldest entry; repeats while the window is too full.
                    wsum_x_reg <= wsum_x_reg - WSW'($signed(rd_data_reg[23:0]));
                    wsum_y_reg <= wsum_y_reg - WSW'($signed(rd_data_reg[47:24]));
                    fill_reg   <= fill_reg - FW'(1);
                    state_reg  <= ST_W_CHK;
                end
                ST_W_PUSH: begin
                    head_reg   <= head_reg + AW'(1);
                    fill_reg   <= fill_reg + FW'(1);
                    wsum_x_reg <= wsum_x_reg + WSW'(cdx_reg);
                    wsum_y_reg <= wsum_y_reg + WSW'(cdy_reg);
                    sel_reg    <= SEL_AX;
                    state_reg  <= ST_DIV;
                end
                ST_T_SQX: state_reg <= ST_T_SQY;
                ST_T_SQY: begin
                    t_reg     <= mul_p_reg[47:0];
                    state_reg <= ST_T_THR;
                end
                ST_T_THR: begin
                    t_reg     <= t_reg + mul_p_reg[47:0];
                    state_reg <= ST_T_CMP;
                end
                ST_T_CMP: begin
                    if (t_reg < mul_p_reg[47:0]) begin
                        ax_reg <= '0;
                        ay_reg <= '0;
                    end
                    state_reg <= ST_P_X;
                end
                ST_P_X: state_reg <= ST_P_XA;
                ST_P_XA: begin
                    pos_x_reg <= move_pos(pos_x_reg, ax_reg[23], mul_p_reg[39:6],
                                          ftint_pkg::POS_X_MAX);
                    state_reg <= ST_P_YA;
                end
                ST_P_YA: begin
                    pos_y_reg <= move_pos(pos_y_reg, ay_reg[23], mul_p_reg[39:6],
                                          ftint_pkg::POS_Y_MAX);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg           <= 1'b1;
                        out_reg.mean_dx         <= mdx_reg;
                        out_reg.mean_dy         <= mdy_reg;
                        out_reg.clipped_mean_dx <= cdx_reg;
                        out_reg.clipped_mean_dy <= cdy_reg;
                        out_reg.smooth_dx       <= ax_reg;
                        out_reg.smooth_dy       <= ay_reg;
                        out_reg.track_x         <= pos_x_reg[PW-1:10];
                        out_reg.track_y         <= pos_y_reg[PW-1:10];
                        out_reg.mag_mean        <= mmag_reg;
                        out_reg.peak_magnitude  <= peak_reg;
                        out_reg.unclipped_count <= 22'(kept_reg);
                        raw_x_reg   <= '0;
                        raw_y_reg   <= '0;
                        clip_x_reg  <= '0;
                        clip_y_reg  <= '0;
                        mag_sum_reg <= '0;
                        peak_reg    <= '0;
                        pix_cnt_reg <= '0;
                        kept_reg    <= '0;
                        state_reg   <= ST_FETCH;
                    end
                end
                default: state_reg <= ST_FETCH;
            endcase
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;
endmodule
`default_nettype wire

@@ hw/rtl/flow_trajectory_integrator.sv @@
// Each pixel runs the square root unit for its magnitude; a clipped pixel also uses the shared
// serial divider and the 2-bit square root unit, which run twice per clip, once per component.
// A frame end adds seven divisions plus a window step per dropped window entry.
// One item in flight in the back end; a 4-entry queue and an output register decouple ports.
// Reset (synchronous, aresetn low) clears sums, counts and window fill, centers the
// position and restores register defaults; the window memory itself is not cleared.
`default_nettype none
module flow_trajectory_integrator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // flow_dx[15:0], flow_dy[31:16]
    input  wire logic         s_tlast,   // frame_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [239:0]      m_tdata,   // mean_dx, mean_dy, clipped_mean_dx, clipped_mean_dy,
                                         // smooth_dx, smooth_dy (24 each), track_x, track_y
                                         // (16 each), mag_mean 24, peak_magnitude 16,
                                         // unclipped_count 22, 2 zero bits
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    ftint_pkg::cfg_t    cfg_reg;
    ftint_pkg::item_t   q_item;
    ftint_pkg::result_t result;
    logic               q_valid;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip <= ftint_pkg::CLIP_RESET;
            cfg_reg.thr  <= ftint_pkg::THR_RESET;
            cfg_reg.wlen <= ftint_pkg::WLEN_RESET;
            cfg_reg.gain <= ftint_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ftint_pkg::CFG_CLIP: cfg_reg.clip <= cfg_data[14:0];
                ftint_pkg::CFG_THR:  cfg_reg.thr  <= cfg_data;
                ftint_pkg::CFG_WLEN: cfg_reg.wlen <= cfg_data[6:0];
                ftint_pkg::CFG_GAIN: cfg_reg.gain <= cfg_data;
                default:             cfg_reg      <= cfg_reg;
            endcase
        end
    end

    ftint_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    ftint_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_result(result)
    );

    assign m_tdata = {2'b00, result};
endmodule
`default_nettype wire
